// File: sv/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared types and codes of the first-fit slot allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // request codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;
  localparam logic SIZE_ONE    = 1'b0;
  localparam logic SIZE_PAIR   = 1'b1;

  // hit vector is encoded in groups of eight slots
  localparam int GRP_SIZE  = 8;
  localparam int GRP_OFF_W = 3;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_GROUP,
    S_PICK,
    S_APPLY
  } state_e;

  // request as seen by every cell
  typedef struct packed {
    logic alloc;   // allocate, else release
    logic pair;    // two-unit item
    logic tag_ok;  // tag nonzero after masking
    logic update;  // commit the selected slot(s) this cycle
  } cell_ctl_t;

endpackage

// File: sv/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell
// one slot: owner tag, local fit/match flags, neighbor hand-off for pairs
// ----------------------------------------------------------------------------
module ffsa_cell
  import ffsa_pkg::*;
#(
  parameter int OWNER_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  cell_ctl_t             ctl_i,
  input  logic [OWNER_BITS-1:0] tag_i,
  input  logic                  in_range_i,
  input  logic                  in_range_next_i,
  input  logic                  free_next_i,
  input  logic                  sel_i,
  input  logic                  sel_prev_i,
  output logic                  free_o,
  output logic                  match_o,
  output logic                  hit_o,
  output logic                  sel_o
);

  logic [OWNER_BITS-1:0] owner_q, owner_d;

  // local flags
  assign free_o  = (owner_q == '0);
  assign match_o = in_range_i && (owner_q == tag_i);
  assign sel_o   = sel_i;

  always_comb begin
    if (ctl_i.alloc) begin
      hit_o = ctl_i.tag_ok && in_range_i && free_o &&
              (!ctl_i.pair || (in_range_next_i && free_next_i));
    end else begin
      hit_o = ctl_i.tag_ok && match_o;
    end
  end

  // commit: this slot is the first one, or the second of a pair
  always_comb begin
    owner_d = owner_q;
    if (ctl_i.update) begin
      if (ctl_i.alloc) begin
        if (sel_i || (sel_prev_i && ctl_i.pair)) begin
          owner_d = tag_i;
        end
      end else begin
        if (sel_i || (sel_prev_i && ctl_i.pair && match_o)) begin
          owner_d = '0;
        end
      end
    end
    if (clear_i) begin
      owner_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else begin
      owner_q <= owner_d;
    end
  end

endmodule

// File: sv/ffsa_grp.sv
// ----------------------------------------------------------------------------
// ffsa_grp
// registered first-hit encoder for each group of eight slots
// ----------------------------------------------------------------------------
module ffsa_grp
  import ffsa_pkg::*;
#(
  parameter int NUM_GRP = 8
) (
  input  logic                                clk_i,
  input  logic [NUM_GRP*GRP_SIZE-1:0]         hit_i,
  output logic [NUM_GRP-1:0]                  any_o,
  output logic [NUM_GRP-1:0][GRP_OFF_W-1:0]   off_o
);

  logic [NUM_GRP-1:0]                any_d;
  logic [NUM_GRP-1:0][GRP_OFF_W-1:0] off_d;

  // lowest hit inside each group
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      any_d[g] = |hit_i[g*GRP_SIZE +: GRP_SIZE];
      off_d[g] = '0;
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (hit_i[g*GRP_SIZE + j]) begin
          off_d[g] = GRP_OFF_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    any_o <= any_d;
    off_o <= off_d;
  end

endmodule

// File: sv/first_fit_slot_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_slot_allocator
// first-fit allocator over a row of owner-tagged slots
// ----------------------------------------------------------------------------
// Each request (allocate or release, one or two slots) returns one result
// item. The slots live in a row of cells; every cell flags whether it fits
// the request, looking at its right neighbor for a pair. The flags are then
// registered, encoded per group of eight, the lowest group is picked, and
// the chosen cell (and its neighbor for a pair) is updated. The steps run
// through the states S_MARK, S_GROUP, S_PICK and S_APPLY; an item waits in
// S_APPLY while the result register is full and not taken. The next item is
// accepted in the cycle the result is written, so no new item is taken while
// one is still in progress. Writing the slot count (cfg_we_i) frees every slot.
module first_fit_slot_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SLOTS  = 64,
  parameter int OWNER_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] owner_id_i,
  input  logic       item_size_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [5:0] slot_index_o,
  output logic [6:0] free_slots_o
);

  localparam int IdxW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CntW   = $clog2(MAX_SLOTS + 1);
  localparam int CmpW   = (CntW > 7) ? CntW : 7;
  localparam int NumGrp = (MAX_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PadN   = NumGrp * GRP_SIZE;
  localparam int ResetN = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  state_e state_q, state_d;

  logic [CntW-1:0]       n_q, n_new;
  logic [CntW-1:0]       free_q, free_d;
  logic                  cmd_q, pair_q;
  logic [OWNER_BITS-1:0] tag_q;
  logic                  in_acc, advance;

  logic [MAX_SLOTS-1:0]  in_range, free, match, hit, sel, sel_out, mnext;
  logic [PadN-1:0]       hit_q;
  logic [NumGrp-1:0]                 grp_any;
  logic [NumGrp-1:0][GRP_OFF_W-1:0]  grp_off;
  logic [IdxW-1:0]       k_q, k_d;
  logic                  found_q, found_d;
  cell_ctl_t             ctl;

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [IdxW-1:0]       index_q;
  logic [CntW-1:0]       free_out_q;

  // fsm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    advance    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_MARK;
        end
      end
      S_MARK:  state_d = S_GROUP;
      S_GROUP: state_d = S_PICK;
      S_PICK:  state_d = S_APPLY;
      S_APPLY: begin
        if (!out_valid_q || out_ready_i) begin
          advance    = 1'b1;
          in_ready_o = 1'b1;
          state_d    = in_valid_i ? S_MARK : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_i;
      pair_q <= item_size_i;
      tag_q  <= OWNER_BITS'(owner_id_i);
    end
  end

  // effective slot count
  assign n_new = (CmpW'(cfg_wdata_i) > CmpW'(MAX_SLOTS)) ? CntW'(MAX_SLOTS)
                                                         : CntW'(cfg_wdata_i);

  assign ctl.alloc  = (cmd_q == CMD_ALLOC);
  assign ctl.pair   = (pair_q == SIZE_PAIR);
  assign ctl.tag_ok = (tag_q != '0);
  assign ctl.update = advance && found_q;

  // row of cells
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    localparam logic [CntW-1:0] CellN = CntW'(i);
    localparam logic [IdxW-1:0] CellK = IdxW'(i);
    logic rng_nx, free_nx, sel_pv;

    assign in_range[i] = (CellN < n_q);
    assign sel[i]      = found_q && (k_q == CellK);

    if (i == MAX_SLOTS - 1) begin : g_last
      assign rng_nx   = 1'b0;
      assign free_nx  = 1'b0;
      assign mnext[i] = 1'b0;
    end else begin : g_mid
      assign rng_nx   = in_range[i+1];
      assign free_nx  = free[i+1];
      assign mnext[i] = match[i+1];
    end

    if (i == 0) begin : g_first
      assign sel_pv = 1'b0;
    end else begin : g_rest
      assign sel_pv = sel_out[i-1];
    end

    ffsa_cell #(
      .OWNER_BITS(OWNER_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .clear_i        (cfg_we_i),
      .ctl_i          (ctl),
      .tag_i          (tag_q),
      .in_range_i     (in_range[i]),
      .in_range_next_i(rng_nx),
      .free_next_i    (free_nx),
      .sel_i          (sel[i]),
      .sel_prev_i     (sel_pv),
      .free_o         (free[i]),
      .match_o        (match[i]),
      .hit_o          (hit[i]),
      .sel_o          (sel_out[i])
    );
  end

  // register the hit flags, padded to whole groups
  always_ff @(posedge clk_i) begin
    hit_q <= PadN'(hit);
  end

  ffsa_grp #(
    .NUM_GRP(NumGrp)
  ) u_grp (
    .clk_i(clk_i),
    .hit_i(hit_q),
    .any_o(grp_any),
    .off_o(grp_off)
  );

  // lowest group with a hit
  always_comb begin
    found_d = 1'b0;
    k_d     = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found_d = 1'b1;
        k_d     = IdxW'(g * GRP_SIZE + int'(grp_off[g]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      k_q     <= '0;
    end else if (state_q == S_PICK) begin
      found_q <= found_d;
      k_q     <= k_d;
    end
  end

  // free count and result
  always_comb begin
    free_d   = free_q;
    status_d = ST_DONE;
    if (!found_q) begin
      status_d = ctl.alloc ? ST_NO_FIT : ST_NOT_FOUND;
    end else if (ctl.alloc) begin
      free_d = free_q - (ctl.pair ? CntW'(2) : CntW'(1));
    end else begin
      free_d = free_q + CntW'(1) + CntW'(ctl.pair && mnext[k_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= CntW'(ResetN);
      free_q <= CntW'(ResetN);
    end else if (cfg_we_i) begin
      n_q    <= n_new;
      free_q <= n_new;
    end else if (advance) begin
      free_q <= free_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q   <= status_d;
      index_q    <= found_q ? k_q : '0;
      free_out_q <= free_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = 6'(index_q);
  assign free_slots_o = 7'(free_out_q);

  // checks
  a_free_le_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= n_q)
    else $error("free count above slot count");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel))
    else $error("more than one slot selected");

  a_fail_keeps_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !found_q && !cfg_we_i) |=> (free_q == $past(free_q)))
    else $error("failed request changed free count");

endmodule

// File: tb/ffsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_checker
// result checker for the first-fit slot allocator
// ----------------------------------------------------------------------------
// Watches the configuration port and both item channels. Every accepted
// request is run through a local copy of the slot table, and the grant it
// should produce is queued. Every accepted result is compared field by field
// with the oldest queued grant. Mismatches and stray results are counted.
// ----------------------------------------------------------------------------
module ffsa_checker
  import ffsa_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       cmd_i,
  input  logic [7:0] owner_id_i,
  input  logic       item_size_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] status_i,
  input  logic [5:0] slot_index_i,
  input  logic [6:0] free_slots_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  typedef struct packed {
    status_e    status;
    logic [5:0] first_slot;
    logic [6:0] free;
  } grant_t;

  logic [7:0] owner_tab [MAX_SLOTS];
  logic [6:0] slot_count;
  logic [6:0] free_left;
  grant_t     due_grants [$];

  // slot counts above the table size act as the table size
  function automatic int live_slots();
    return (int'(slot_count) > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
  endfunction

  // a new slot count frees the whole table
  task automatic wipe_slots(input logic [6:0] count);
    slot_count = count;
    foreach (owner_tab[i]) owner_tab[i] = '0;
    free_left = 7'(live_slots());
  endtask

  // apply one request to the local slot table and return its grant
  function automatic grant_t serve_request(input logic cmd, input logic [7:0] owner,
                                           input logic size);
    grant_t g;
    int     n;
    n = live_slots();
    g.status     = (cmd == CMD_RELEASE) ? ST_NOT_FOUND : ST_NO_FIT;
    g.first_slot = '0;
    if (owner != '0) begin
      if (cmd == CMD_ALLOC) begin
        for (int i = 0; i < n; i++) begin
          if (size == SIZE_ONE) begin
            if (owner_tab[i] == '0) begin
              owner_tab[i] = owner;
              free_left    = free_left - 7'd1;
              g.status     = ST_DONE;
              g.first_slot = 6'(i);
              break;
            end
          end else if (i + 1 < n && owner_tab[i] == '0 && owner_tab[i+1] == '0) begin
            owner_tab[i]   = owner;
            owner_tab[i+1] = owner;
            free_left      = free_left - 7'd2;
            g.status       = ST_DONE;
            g.first_slot   = 6'(i);
            break;
          end
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          if (owner_tab[i] == owner) begin
            owner_tab[i] = '0;
            free_left    = free_left + 7'd1;
            // neighbor is freed only inside the range and with the same tag
            if (size == SIZE_PAIR && i + 1 < n && owner_tab[i+1] == owner) begin
              owner_tab[i+1] = '0;
              free_left      = free_left + 7'd1;
            end
            g.status     = ST_DONE;
            g.first_slot = 6'(i);
            break;
          end
        end
      end
    end
    g.free = free_left;
    return g;
  endfunction

  // track requests and check results
  always @(posedge clk_i or negedge rst_ni) begin : track
    grant_t want;
    bit     bad;
    if (!rst_ni) begin
      wipe_slots(7'd64);
      due_grants.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        wipe_slots(cfg_wdata_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (due_grants.size() == 0) begin
          $display("%0t: result item with none expected: status %0d index %0d free %0d",
                   $realtime, status_i, slot_index_i, free_slots_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = due_grants.pop_front();
          bad  = 1'b0;
          if (status_i !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $realtime, want.status, status_i);
            bad = 1'b1;
          end
          if (slot_index_i !== want.first_slot) begin
            $display("%0t: slot_index mismatch, expected %0d got %0d",
                     $realtime, want.first_slot, slot_index_i);
            bad = 1'b1;
          end
          if (free_slots_i !== want.free) begin
            $display("%0t: free_slots mismatch, expected %0d got %0d",
                     $realtime, want.free, free_slots_i);
            bad = 1'b1;
          end
          if (bad) mismatch_count_o <= mismatch_count_o + 1;
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_grants.push_back(serve_request(cmd_i, owner_id_i, item_size_i));
      end
      pending_o <= due_grants.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the first-fit slot allocator
// ----------------------------------------------------------------------------
// After reset a short directed run covers tag extremes, zero tags, both
// commands and sizes, pairs at the end of the range, partial pair releases
// and slot counts of 0, 1, 2 and beyond the table. Then random phases run
// over several slot counts with a small owner pool so that releases hit.
// The sender works in bursts, the receiver stalls on its own pattern and
// twice holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench
  import ffsa_pkg::*;
();

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       cmd_i;
  logic [7:0] owner_id_i;
  logic       item_size_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] status_o;
  logic [5:0] slot_index_o;
  logic [6:0] free_slots_o;

  int mismatch_count;
  int pending;
  int hold_asks;
  int holds_served;

  first_fit_slot_allocator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .owner_id_i   (owner_id_i),
    .item_size_i  (item_size_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .free_slots_o (free_slots_o)
  );

  ffsa_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .cmd_i            (cmd_i),
    .owner_id_i       (owner_id_i),
    .item_size_i      (item_size_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .slot_index_i     (slot_index_o),
    .free_slots_i     (free_slots_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // offer one request and hold it until accepted
  task automatic send_req(input logic cmd, input logic [7:0] owner, input logic size);
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    owner_id_i  <= owner;
    item_size_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drain all outstanding results, then write the slot count
  task automatic set_slot_count(input logic [6:0] count);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly a small owner pool so releases find their slots
  function automatic logic [7:0] pick_owner();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(1, 5));
    if (r < 95) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // random requests in bursts with optional gaps
  task automatic run_phase(input int items, input bit steady, input int alloc_pct);
    int   left;
    int   burst;
    int   gap;
    logic cmd;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) begin
        cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_RELEASE;
        send_req(cmd, pick_owner(), $urandom_range(0, 1) ? SIZE_PAIR : SIZE_ONE);
      end
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (!steady && gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // receiver: own stall pattern, with long hold-offs on request
  initial begin : receiver
    int cyc;
    int mode;
    out_ready_i  <= 1'b0;
    holds_served = 0;
    cyc          = 0;
    mode         = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_asks != holds_served) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        holds_served++;
      end else begin
        if (cyc % 128 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready_i <= (cyc % 5 != 0) && (cyc % 7 != 3);
          end
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int slot_counts [9];
    int alloc_pcts  [9];
    slot_counts = '{64, 3, 8, 127, 17, 2, 40, 1, 64};
    alloc_pcts  = '{65, 55, 60, 70, 55, 50, 60, 50, 55};
    slot_counts[6] = $urandom_range(2, 64);
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_ALLOC;
    owner_id_i  <= '0;
    item_size_i <= SIZE_ONE;
    hold_asks   <= 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset slot count, tag extremes and zero tag
    send_req(CMD_ALLOC,   8'd1,   SIZE_ONE);
    send_req(CMD_ALLOC,   8'd255, SIZE_PAIR);
    send_req(CMD_ALLOC,   8'd0,   SIZE_ONE);
    send_req(CMD_RELEASE, 8'd0,   SIZE_ONE);
    send_req(CMD_RELEASE, 8'd7,   SIZE_ONE);
    send_req(CMD_ALLOC,   8'd128, SIZE_ONE);
    send_req(CMD_RELEASE, 8'd255, SIZE_PAIR);
    send_req(CMD_ALLOC,   8'd2,   SIZE_PAIR);
    // pair release where the neighbor has another tag
    send_req(CMD_RELEASE, 8'd1,   SIZE_PAIR);
    send_req(CMD_RELEASE, 8'd2,   SIZE_ONE);
    send_req(CMD_RELEASE, 8'd2,   SIZE_ONE);
    send_req(CMD_RELEASE, 8'd128, SIZE_ONE);

    // two slots: pair fills the range, no pair past the end
    set_slot_count(7'd2);
    send_req(CMD_ALLOC,   8'd3, SIZE_PAIR);
    send_req(CMD_ALLOC,   8'd4, SIZE_ONE);
    send_req(CMD_RELEASE, 8'd3, SIZE_PAIR);
    send_req(CMD_ALLOC,   8'd5, SIZE_ONE);
    send_req(CMD_ALLOC,   8'd6, SIZE_PAIR);
    send_req(CMD_ALLOC,   8'd6, SIZE_ONE);

    // empty range
    set_slot_count(7'd0);
    send_req(CMD_ALLOC,   8'd9, SIZE_ONE);
    send_req(CMD_RELEASE, 8'd9, SIZE_ONE);

    // single slot: a pair never fits, pair release stops at the end
    set_slot_count(7'd1);
    send_req(CMD_ALLOC,   8'd9, SIZE_PAIR);
    send_req(CMD_ALLOC,   8'd9, SIZE_ONE);
    send_req(CMD_RELEASE, 8'd9, SIZE_PAIR);

    // slot count above the table size
    set_slot_count(7'd127);
    send_req(CMD_ALLOC,   8'h55, SIZE_PAIR);
    send_req(CMD_RELEASE, 8'hAA, SIZE_ONE);

    // random phases over several slot counts
    foreach (slot_counts[p]) begin
      set_slot_count(7'(slot_counts[p]));
      if (p == 2 || p == 5) hold_asks <= hold_asks + 1;
      run_phase(150, (p % 3 == 1), alloc_pcts[p]);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
